### rtl/tmr_pkg.sv
package tmr_pkg;

  localparam int LANES         = 8;
  localparam int DW            = 32;
  localparam int MAX_SLICE_DEF = 1024;

  // result queue depth: one entry on display, one landing from the pipe, one spare
  localparam int QD = 3;

  // configuration register indexes
  localparam logic [1:0] REG_VECS   = 2'd0;
  localparam logic [1:0] REG_ROWS   = 2'd1;
  localparam logic [1:0] REG_GROUPS = 2'd2;

  typedef logic [LANES-1:0][DW-1:0] vec_t;

  typedef struct packed {
    logic first;
    logic last_row;
    logic last_vec;
    logic last_group;
  } ctl_t;

  typedef struct packed {
    vec_t maxv;
    logic slice_end;
    logic run_end;
  } res_t;

endpackage

### rtl/tmr_seq.sv
module tmr_seq
  import tmr_pkg::*;
#(
  parameter int VEC_CAP = MAX_SLICE_DEF / LANES,
  parameter int AW      = (VEC_CAP > 1) ? $clog2(VEC_CAP) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  input  logic          adv,
  output logic [AW-1:0] addr,
  output ctl_t          ctl
);

  localparam logic [15:0] CAP16 = 16'(VEC_CAP);

  logic [7:0]    vecs_per_slice;
  logic [15:0]   rows_per_group;
  logic [19:0]   group_count;
  logic [AW-1:0] vector_index;
  logic [15:0]   row_index;
  logic [19:0]   group_index;

  logic [15:0] eff_vecs, vidx16, vi16, eff_rows;
  logic [19:0] eff_groups;
  logic        last_vec, last_row, last_group;

  always_comb begin
    eff_vecs = {8'd0, vecs_per_slice};
    if (eff_vecs == 16'd0) eff_vecs = 16'd1;
    if (eff_vecs > CAP16) eff_vecs = CAP16;
    vidx16     = 16'(vector_index);
    last_vec   = vidx16 >= (eff_vecs - 16'd1);
    // a counter left past the end by a config change sits at the last position
    vi16       = last_vec ? (eff_vecs - 16'd1) : vidx16;
    eff_rows   = (rows_per_group == 16'd0) ? 16'd1 : rows_per_group;
    eff_groups = (group_count == 20'd0) ? 20'd1 : group_count;
    last_row   = row_index >= (eff_rows - 16'd1);
    last_group = group_index >= (eff_groups - 20'd1);
  end

  assign addr           = vi16[AW-1:0];
  assign ctl.first      = (row_index == 16'd0);
  assign ctl.last_row   = last_row;
  assign ctl.last_vec   = last_vec;
  assign ctl.last_group = last_group;

  always_ff @(posedge clk) begin
    if (rst) begin
      vecs_per_slice <= 8'd1;
      rows_per_group <= 16'd1;
      group_count    <= 20'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VECS:   vecs_per_slice <= cfg_data[7:0];
        REG_ROWS:   rows_per_group <= cfg_data[15:0];
        REG_GROUPS: group_count    <= cfg_data[19:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_index <= '0;
      row_index    <= 16'd0;
      group_index  <= 20'd0;
    end else if (adv) begin
      if (last_vec) begin
        vector_index <= '0;
        if (last_row) begin
          row_index   <= 16'd0;
          group_index <= last_group ? 20'd0 : group_index + 20'd1;
        end else begin
          row_index <= row_index + 16'd1;
        end
      end else begin
        vector_index <= vi16[AW-1:0] + AW'(1);
      end
    end
  end

endmodule

### rtl/tmr_slice.sv
module tmr_slice
  import tmr_pkg::*;
#(
  parameter int VEC_CAP = MAX_SLICE_DEF / LANES,
  parameter int AW      = (VEC_CAP > 1) ? $clog2(VEC_CAP) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_acc,
  input  vec_t          lanes,
  input  logic [AW-1:0] addr,
  input  ctl_t          ctl,
  output logic          busy,
  output logic          push,
  output res_t          res
);

  // one row per vector position, all lanes side by side
  vec_t mem [VEC_CAP];

  logic          s1_valid;
  vec_t          s1_data;
  logic [AW-1:0] s1_addr;
  ctl_t          s1_ctl;
  vec_t          rd_data;
  logic          fwd_hit;
  vec_t          fwd_data;
  vec_t          old;
  vec_t          wdata;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= in_acc;
  end

  always_ff @(posedge clk) begin
    if (s1_valid) mem[s1_addr] <= wdata;
    if (in_acc) begin
      s1_data  <= lanes;
      s1_addr  <= addr;
      s1_ctl   <= ctl;
      rd_data  <= mem[addr];
      // write to the same row on this edge is not yet in the read data
      fwd_hit  <= s1_valid && (s1_addr == addr);
      fwd_data <= wdata;
    end
  end

  always_comb begin
    old = fwd_hit ? fwd_data : rd_data;
    for (int k = 0; k < LANES; k++) begin
      wdata[k] = (s1_ctl.first || ($signed(s1_data[k]) > $signed(old[k])))
                 ? s1_data[k] : old[k];
    end
  end

  assign busy          = s1_valid;
  assign push          = s1_valid && s1_ctl.last_row;
  assign res.maxv      = wdata;
  assign res.slice_end = s1_ctl.last_vec;
  assign res.run_end   = s1_ctl.last_vec && s1_ctl.last_group;

endmodule

### rtl/tmr_outq.sv
module tmr_outq
  import tmr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  res_t       din,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       dout,
  output logic [1:0] count
);

  res_t       q [QD];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign dout      = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == 2'(QD - 1)) ? 2'd0 : wr_ptr + 2'd1;
      if (pop)  rd_ptr <= (rd_ptr == 2'(QD - 1)) ? 2'd0 : rd_ptr + 2'd1;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/tensor_middle_axis_max_reduce_core.sv
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    lane0..lane7
// out       output     out_valid/out_ready  max0..max7, slice_end, run_end
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One vector per cycle while in_ready is high. A vector reads its slice row
// from the buffer RAM on acceptance and writes it back in the next cycle;
// back-to-back hits on the same row are forwarded. Results go through the
// s1 register and the result queue. Reset clears counters and sets registers
// to 1; the buffer is not cleared. in_ready drops only when the 3-entry result
// queue plus the vector in flight could overflow under a stalled out_ready.
module tensor_middle_axis_max_reduce_core
  import tmr_pkg::*;
#(
  parameter int MAX_SLICE = MAX_SLICE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] lane0,
  input  logic [31:0] lane1,
  input  logic [31:0] lane2,
  input  logic [31:0] lane3,
  input  logic [31:0] lane4,
  input  logic [31:0] lane5,
  input  logic [31:0] lane6,
  input  logic [31:0] lane7,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] max0,
  output logic [31:0] max1,
  output logic [31:0] max2,
  output logic [31:0] max3,
  output logic [31:0] max4,
  output logic [31:0] max5,
  output logic [31:0] max6,
  output logic [31:0] max7,
  output logic        slice_end,
  output logic        run_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int VEC_CAP = MAX_SLICE / LANES;
  localparam int AW      = (VEC_CAP > 1) ? $clog2(VEC_CAP) : 1;

  logic          in_acc;
  vec_t          lanes;
  logic [AW-1:0] addr;
  ctl_t          ctl;
  logic          busy;
  logic          push;
  res_t          res;
  res_t          dout;
  logic [1:0]    count;
  logic [2:0]    pending;

  assign cfg_ready = 1'b1;
  assign pending   = {1'b0, count} + {2'b00, busy};
  assign in_ready  = pending < 3'(QD);
  assign in_acc    = in_valid && in_ready;

  assign lanes[0] = lane0;
  assign lanes[1] = lane1;
  assign lanes[2] = lane2;
  assign lanes[3] = lane3;
  assign lanes[4] = lane4;
  assign lanes[5] = lane5;
  assign lanes[6] = lane6;
  assign lanes[7] = lane7;

  tmr_seq #(
    .VEC_CAP (VEC_CAP),
    .AW      (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .adv       (in_acc),
    .addr      (addr),
    .ctl       (ctl)
  );

  tmr_slice #(
    .VEC_CAP (VEC_CAP),
    .AW      (AW)
  ) u_slice (
    .clk    (clk),
    .rst    (rst),
    .in_acc (in_acc),
    .lanes  (lanes),
    .addr   (addr),
    .ctl    (ctl),
    .busy   (busy),
    .push   (push),
    .res    (res)
  );

  tmr_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (dout),
    .count     (count)
  );

  assign max0      = dout.maxv[0];
  assign max1      = dout.maxv[1];
  assign max2      = dout.maxv[2];
  assign max3      = dout.maxv[3];
  assign max4      = dout.maxv[4];
  assign max5      = dout.maxv[5];
  assign max6      = dout.maxv[6];
  assign max7      = dout.maxv[7];
  assign slice_end = dout.slice_end;
  assign run_end   = dout.run_end;

endmodule

### test/tb_tensor_middle_axis_max_reduce_core.sv
`timescale 1ns / 1ps

module tb_tensor_middle_axis_max_reduce_core;
  import tmr_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int VEC_CAP = MAX_SLICE_DEF / LANES;
  localparam int RANDOM_ITEMS = 450;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_STALL = 150;
  localparam int STUCK_LIMIT = 2000;

  class max_reduce_scoreboard;
    logic [DW-1:0] slice_buf [MAX_SLICE_DEF];
    int unsigned vec_idx;
    int unsigned row_idx;
    int unsigned grp_idx;
    logic [7:0] vecs_reg;
    logic [15:0] rows_reg;
    logic [19:0] groups_reg;
    res_t expected_maxima[$];
    int errors;

    function new();
      foreach (slice_buf[i]) slice_buf[i] = '0;
      vec_idx = 0;
      row_idx = 0;
      grp_idx = 0;
      vecs_reg = 8'd1;
      rows_reg = 16'd1;
      groups_reg = 20'd1;
      errors = 0;
    endfunction

    // zero acts as one, anything above cap saturates
    static function int unsigned clamp_count(int unsigned v, int unsigned cap);
      if (v == 0) return 1;
      if (v > cap) return cap;
      return v;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_VECS: vecs_reg = data[7:0];
        REG_ROWS: rows_reg = data[15:0];
        REG_GROUPS: groups_reg = data[19:0];
        default: ;
      endcase
    endfunction

    function void accept_vector(vec_t v);
      int unsigned vps;
      int unsigned rpg;
      int unsigned gc;
      int unsigned vi;
      int unsigned pos;
      bit last_vec;
      bit last_row;
      bit last_group;
      res_t r;
      vps = clamp_count(vecs_reg, VEC_CAP);
      rpg = clamp_count(rows_reg, 32'hFFFF);
      gc = clamp_count(groups_reg, 32'hFFFFF);
      last_vec = vec_idx >= vps - 1;
      last_row = row_idx >= rpg - 1;
      last_group = grp_idx >= gc - 1;
      vi = (vec_idx < vps) ? vec_idx : vps - 1;
      for (int k = 0; k < LANES; k++) begin
        pos = (vi * LANES + k) % MAX_SLICE_DEF;
        if (row_idx == 0 || $signed(v[k]) > $signed(slice_buf[pos])) slice_buf[pos] = v[k];
      end
      if (last_row) begin
        for (int k = 0; k < LANES; k++) r.maxv[k] = slice_buf[(vi * LANES + k) % MAX_SLICE_DEF];
        r.slice_end = last_vec;
        r.run_end = last_vec && last_group;
        expected_maxima.push_back(r);
      end
      if (last_vec) begin
        vec_idx = 0;
        if (last_row) begin
          row_idx = 0;
          grp_idx = last_group ? 0 : ((grp_idx + 1) & 32'hFFFFF);
        end else begin
          row_idx = (row_idx + 1) & 32'hFFFF;
        end
      end else begin
        vec_idx = vi + 1;
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_maxima(res_t got);
      res_t want;
      if (expected_maxima.size() == 0) begin
        report("result transaction with nothing expected");
        return;
      end
      want = expected_maxima.pop_front();
      for (int k = 0; k < LANES; k++) begin
        if (got.maxv[k] !== want.maxv[k])
          report($sformatf("max%0d got %h expected %h", k, got.maxv[k], want.maxv[k]));
      end
      if (got.slice_end !== want.slice_end)
        report($sformatf("slice_end got %b expected %b", got.slice_end, want.slice_end));
      if (got.run_end !== want.run_end)
        report($sformatf("run_end got %b expected %b", got.run_end, want.run_end));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  vec_t in_vec = '0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_index = REG_VECS;
  logic [31:0] cfg_data = '0;
  logic long_stall_req = 1'b0;
  logic long_stall_done = 1'b0;
  wire in_ready;
  wire out_valid;
  wire cfg_ready;
  wire slice_end;
  wire run_end;
  wire [DW-1:0] max_w [LANES];

  int burst_left = 0;
  int random_sent = 0;
  int stuck_cycles = 0;

  max_reduce_scoreboard sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tensor_middle_axis_max_reduce_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .lane0     (in_vec[0]),
    .lane1     (in_vec[1]),
    .lane2     (in_vec[2]),
    .lane3     (in_vec[3]),
    .lane4     (in_vec[4]),
    .lane5     (in_vec[5]),
    .lane6     (in_vec[6]),
    .lane7     (in_vec[7]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .max0      (max_w[0]),
    .max1      (max_w[1]),
    .max2      (max_w[2]),
    .max3      (max_w[3]),
    .max4      (max_w[4]),
    .max5      (max_w[5]),
    .max6      (max_w[6]),
    .max7      (max_w[7]),
    .slice_end (slice_end),
    .run_end   (run_end),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // input, config and result transactions, in that order within one edge;
  // an input taken on the edge of a config write still sees the old registers
  always @(posedge clk) begin
    res_t got;
    if (!rst) begin
      if (in_valid && in_ready) sb.accept_vector(in_vec);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) begin
        for (int k = 0; k < LANES; k++) got.maxv[k] = max_w[k];
        got.slice_end = slice_end;
        got.run_end = run_end;
        sb.check_maxima(got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int mode;
    int left;
    int beat;
    mode = 0;
    left = 0;
    beat = 0;
    forever begin
      @(posedge clk);
      if (long_stall_req && !long_stall_done) begin
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        long_stall_done = 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 150);
        end
        left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= ($urandom_range(0, 3) != 0);
          default: begin
            beat++;
            out_ready <= (beat % 3 != 0);
          end
        endcase
      end
    end
  end

  function automatic logic [31:0] rand_lane();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4, 5: return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  function automatic vec_t splat(logic [31:0] x);
    vec_t v;
    for (int k = 0; k < LANES; k++) v[k] = x;
    return v;
  endfunction

  // random bits above the register width, half the time
  function automatic logic [31:0] reg_data(int unsigned value, int width);
    logic [31:0] junk;
    junk = $urandom();
    if ($urandom_range(0, 1) == 0) return value;
    return (junk << width) | value;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_vec(input vec_t v);
    in_valid <= 1'b1;
    in_vec <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic sender_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic stream_vectors(input int n);
    vec_t v;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(30, 80);
        end else begin
          sender_gap($urandom_range(1, 5));
          burst_left = $urandom_range(1, 12);
        end
      end
      burst_left--;
      for (int k = 0; k < LANES; k++) v[k] = rand_lane();
      send_vec(v);
      random_sent++;
    end
  endtask

  // drain results, then give rows that produce nothing time to retire
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_maxima.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    vec_t v;
    int unsigned vps_val;
    int unsigned rows_val;
    int unsigned groups_val;
    int unsigned eff_v;
    int unsigned eff_r;
    int unsigned ngroups;
    bit first_phase;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: every vector is a one-row group, emitted as is
    send_vec(splat(32'h7FFF_FFFF));
    send_vec(splat(32'h8000_0000));
    wait_idle();

    // 2 vectors x 3 rows, signed extremes against each other
    write_reg(REG_VECS, 32'hFFFF_FF02);
    write_reg(REG_ROWS, 32'h5A5A_0003);
    write_reg(REG_GROUPS, 32'hFFF0_0001);
    for (int k = 0; k < LANES; k++) v[k] = k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    send_vec(v);
    send_vec(splat(32'hFFFF_FFFF));
    send_vec(splat(32'h0));
    send_vec(splat(32'h0));
    send_vec(splat(32'h8000_0000));
    for (int k = 0; k < LANES; k++) v[k] = rand_lane();
    send_vec(v);
    wait_idle();

    // zero in every register behaves as one
    write_reg(REG_VECS, 32'h0000_0100);
    write_reg(REG_ROWS, 32'h0001_0000);
    write_reg(REG_GROUPS, 32'h0010_0000);
    send_vec(splat(32'h0000_0001));
    wait_idle();
    write_reg(REG_UNUSED, $urandom());

    // largest rows and groups, then rows shrunk below the current row mid-group
    write_reg(REG_VECS, 32'd1);
    write_reg(REG_ROWS, 32'd65535);
    write_reg(REG_GROUPS, 32'd1048575);
    send_vec(splat(32'hFFFF_FFF0));
    send_vec(splat(32'h0001_0000));
    send_vec(splat(32'h8000_0000));
    send_vec(splat(32'h0000_FFFF));
    wait_idle();
    write_reg(REG_ROWS, 32'd2);
    send_vec(splat(32'h0001_0001));
    wait_idle();

    // slice shrunk below the current vector on a later row; group past new count
    write_reg(REG_VECS, 32'd4);
    write_reg(REG_ROWS, 32'd2);
    write_reg(REG_GROUPS, 32'd1);
    for (int i = 0; i < 6; i++) begin
      for (int k = 0; k < LANES; k++) v[k] = rand_lane();
      send_vec(v);
    end
    wait_idle();
    write_reg(REG_VECS, 32'd2);
    for (int k = 0; k < LANES; k++) v[k] = rand_lane();
    send_vec(v);
    wait_idle();

    // random phases, each made of whole groups
    first_phase = 1'b1;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: vps_val = 0;
        1: vps_val = VEC_CAP;
        2: vps_val = $urandom_range(VEC_CAP + 1, 255);
        3, 4, 5: vps_val = $urandom_range(5, 16);
        default: vps_val = $urandom_range(1, 4);
      endcase
      eff_v = max_reduce_scoreboard::clamp_count(vps_val, VEC_CAP);
      case ($urandom_range(0, 9))
        0: rows_val = 0;
        1: rows_val = $urandom_range(5, 8);
        default: rows_val = $urandom_range(1, 4);
      endcase
      if (eff_v >= 64) rows_val = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
        0: groups_val = 0;
        1: groups_val = 20'hFFFFF;
        2: groups_val = $urandom_range(4, 20'hFFFFE);
        default: groups_val = $urandom_range(1, 3);
      endcase
      ngroups = $urandom_range(1, 3);
      if (first_phase) begin
        // one result per transaction so a stalled receiver backs up the input
        vps_val = 1;
        rows_val = 1;
        eff_v = 1;
        ngroups = 40;
        long_stall_req <= 1'b1;
      end
      eff_r = max_reduce_scoreboard::clamp_count(rows_val, 32'hFFFF);
      if (eff_v * eff_r >= 64) ngroups = 1;
      write_reg(REG_VECS, reg_data(vps_val, 8));
      write_reg(REG_ROWS, reg_data(rows_val, 16));
      write_reg(REG_GROUPS, reg_data(groups_val, 20));
      stream_vectors(eff_v * eff_r * ngroups);
      wait_idle();
      first_phase = 1'b0;
    end

    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
